// ===== rtl/crlf_pkg.sv =====
// Shared constants and controller/datapath interface types for the CR LF line receiver.
package crlf_pkg;

  localparam int DEF_LINE_DEPTH = 64;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;        // write the received byte at the current position
    logic set_cr;       // received byte is a carriage return
    logic discard;      // drop the line: clear count and flag
    logic begin_echo;   // line complete: latch its length, clear count and flag
    logic rd_en;        // read one stored byte for the echo
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cr_seen;
    logic is_cr;
    logic is_lf;
    logic rd_last;      // the entry being read is the final one of the line
  } stat_t;

endpackage

// ===== rtl/crlf_datapath.sv =====
// Datapath of the CR LF line receiver: line store, write count, CR flag and echo read side.
module crlf_datapath #(
  parameter int LINE_DEPTH = crlf_pkg::DEF_LINE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           rx_byte,
  input  crlf_pkg::cmd_t       cmd,
  output crlf_pkg::stat_t      stat,
  output logic                 out_strobe,
  output logic [7:0]           out_tx_byte,
  output logic                 out_last_of_line
);

  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int IW = $clog2(LINE_DEPTH);

  logic [7:0]    line_store [LINE_DEPTH];

  logic [CW-1:0] count_r,   count_nxt;
  logic          cr_r,      cr_nxt;
  logic [CW-1:0] len_r,     len_nxt;
  logic [IW-1:0] rd_idx_r,  rd_idx_nxt;
  logic          strobe_r;
  logic          last_r;
  logic [7:0]    rd_data_r;

  logic [IW-1:0] wr_pos;
  logic [CW-1:0] wr_count;
  logic          rd_last;

  // A full buffer wraps the write position back to the start.
  assign wr_pos   = (count_r >= CW'(LINE_DEPTH)) ? '0 : count_r[IW-1:0];
  assign wr_count = CW'(wr_pos) + CW'(1);
  assign rd_last  = (CW'(rd_idx_r) + CW'(1)) == len_r;

  assign stat.cr_seen = cr_r;
  assign stat.is_cr   = (rx_byte == crlf_pkg::CHAR_CR);
  assign stat.is_lf   = (rx_byte == crlf_pkg::CHAR_LF);
  assign stat.rd_last = rd_last;

  always_comb begin
    count_nxt  = count_r;
    cr_nxt     = cr_r;
    len_nxt    = len_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.store) begin
      count_nxt = wr_count;
    end
    if (cmd.set_cr) begin
      cr_nxt = 1'b1;
    end
    if (cmd.discard) begin
      count_nxt = '0;
      cr_nxt    = 1'b0;
    end
    if (cmd.begin_echo) begin
      len_nxt    = wr_count;
      count_nxt  = '0;
      cr_nxt     = 1'b0;
      rd_idx_nxt = '0;
    end else if (cmd.rd_en) begin
      rd_idx_nxt = rd_idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cr_r     <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      cr_r     <= cr_nxt;
      strobe_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    rd_idx_r <= rd_idx_nxt;
    last_r   <= rd_last;
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      line_store[wr_pos] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= line_store[rd_idx_r];
    end
  end

  assign out_strobe       = strobe_r;
  assign out_tx_byte      = rd_data_r;
  assign out_last_of_line = last_r;

endmodule

// ===== rtl/crlf_ctrl.sv =====
// Controller of the CR LF line receiver: decodes accepted bytes and sequences the echo burst.
module crlf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  crlf_pkg::stat_t stat,
  output crlf_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic {
    ST_IDLE,
    ST_ECHO
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    cmd            = '0;
    cmd.store      = accept && (!stat.cr_seen || stat.is_lf);
    cmd.set_cr     = accept && !stat.cr_seen && stat.is_cr;
    cmd.discard    = accept && stat.cr_seen && !stat.is_lf;
    cmd.begin_echo = accept && stat.cr_seen && stat.is_lf;
    cmd.rd_en      = (state_r == ST_ECHO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.begin_echo) begin
            state_r <= ST_ECHO;
            busy_r  <= 1'b1;
          end
        end
        ST_ECHO: begin
          if (stat.rd_last) begin
            state_r <= ST_IDLE;
            busy_r  <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/crlf_line_buffer_echo_core.sv =====
// Top level of the CR LF terminated line receiver with echo of each completed line.
//
// Received bytes are offered on in_rx_byte with start; a byte transfer takes place at a
// rising edge where start is high and busy is low, and in normal running a new byte can be
// taken on every clock cycle. Each byte is written into a line store of LINE_DEPTH entries.
// A carriage return arms the block; a line feed straight after it completes the line, and any
// other byte after a carriage return discards the line without being stored. On completion the
// whole line, carriage return and line feed included, is echoed in stored order on out_tx_byte,
// one byte per cycle, with out_strobe marking each result transfer and out_last_of_line set on
// the final byte. The receiver cannot hold results off, so every strobed cycle must be taken.
// A completed line of n bytes (at most LINE_DEPTH) raises busy while the echo reads the
// single read port of the line store one entry per cycle; each result follows its read in
// the next cycle, because the store's read data is registered straight onto the result
// ports. If more than LINE_DEPTH bytes arrive before the line ends, the write position wraps
// to the start and the carriage-return state is kept, so only the most recent bytes are echoed.
module crlf_line_buffer_echo_core #(
  parameter int LINE_DEPTH = crlf_pkg::DEF_LINE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_rx_byte,
  output logic       out_strobe,
  output logic [7:0] out_tx_byte,
  output logic       out_last_of_line
);

  crlf_pkg::cmd_t  cmd;
  crlf_pkg::stat_t stat;

  // The controller turns each transfer into store, discard or echo commands and steps the
  // echo; the datapath holds the line store, the write count and the carriage-return flag.
  crlf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  crlf_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_byte          (in_rx_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_strobe       (out_strobe),
    .out_tx_byte      (out_tx_byte),
    .out_last_of_line (out_last_of_line)
  );

  // A result only ever follows a cycle in which the echo was running.
  a_strobe_after_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a preceding echo read");

  // A line feed after a carriage return must start the echo in the next cycle.
  a_lf_starts_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && stat.cr_seen && stat.is_lf) |=> busy)
    else $error("completed line did not start an echo");

  // The final byte of a line is the end of the echo: input is open again then.
  a_last_ends_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_of_line) |-> !busy)
    else $error("echo still running after the final byte of the line");

  // A discarded line never produces an echo.
  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.discard |=> !busy)
    else $error("discarded line started an echo");

endmodule
